// File: sv/wtsp_pkg.sv
package wtsp_pkg;

   localparam int COORD_W    = 32;
   localparam int COEF_W     = 32;
   localparam int MUL_W      = COORD_W + COEF_W;
   localparam int FRAC_W     = 16;
   localparam int DOT_W      = 49;
   localparam int MAG_W      = DOT_W - 1;
   localparam int Q_W        = 35;
   localparam int HI_SHIFT   = Q_W - FRAC_W;
   localparam int NSTEP      = Q_W;
   localparam int VP_W       = 16;
   localparam int PROD_W     = Q_W + VP_W;
   localparam int HALF_W     = PROD_W - 1;
   localparam int SUM_W      = 54;
   localparam int W_MIN      = 656;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_LO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_HI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_LO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_HI = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3_LO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3_HI = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_ORG  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_SIZE = 3'd7;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [3:0][COEF_W-1:0] row_type;

   typedef struct packed {
      row_type row_x;
      row_type row_y;
      row_type row_w;
   } matrix_type;

   typedef struct packed {
      logic signed [VP_W-1:0] top;
      logic signed [VP_W-1:0] left;
      logic [VP_W-1:0]        height;
      logic [VP_W-1:0]        width;
   } viewport_type;

   // classified point handed from front to back
   typedef struct packed {
      logic [MAG_W-1:0] mag_x;
      logic             neg_x;
      logic [MAG_W-1:0] mag_y;
      logic             neg_y;
      logic [MAG_W-1:0] div;
      logic             vis;
   } job_type;

   typedef struct packed {
      logic             vld;
      logic             vis;
      logic             neg_x;
      logic             neg_y;
      logic             ovf_x;
      logic             ovf_y;
      logic [MAG_W-1:0] div;
      logic [MAG_W-1:0] rem_x;
      logic [MAG_W-1:0] rem_y;
      logic [Q_W-1:0]   num_x;
      logic [Q_W-1:0]   num_y;
      logic [Q_W-1:0]   quo_x;
      logic [Q_W-1:0]   quo_y;
   } div_stage_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(64'sh7FFF_FFFF);
      lo = -SUM_W'(64'sh8000_0000);
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return COORD_W'(v);
   endfunction

endpackage

// File: sv/wtsp_ifs.sv
interface wtsp_req_if import wtsp_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input point_z,
                 output ready);
endinterface

interface wtsp_rsp_if import wtsp_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type screen_x;
   coord_type screen_y;
   logic      on_screen;

   modport source (output valid, output screen_x, output screen_y, output on_screen,
                   input ready);
   modport sink (input valid, input screen_x, input screen_y, input on_screen,
                 output ready);
endinterface

// File: sv/wtsp_front.sv
module wtsp_front import wtsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wtsp_req_if.sink   req_chan,
   input  matrix_type matrix,
   output job_type    job,
   output logic       job_vld,
   input  logic       job_rdy
);

   coord_type pt [3];
   row_type   rows [3];
   logic      en;

   logic                    s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic signed [MUL_W-1:0] prod_ff [3][3];
   logic signed [COEF_W-1:0] c3_ff [3];
   logic signed [DOT_W-1:0] dot_ff [3];
   job_type                 job_ff;
   job_type                 job_in;

   localparam logic signed [DOT_W-1:0] WMIN_S = DOT_W'(W_MIN);

   assign pt[0] = req_chan.point_x;
   assign pt[1] = req_chan.point_y;
   assign pt[2] = req_chan.point_z;
   assign rows[0] = matrix.row_x;
   assign rows[1] = matrix.row_y;
   assign rows[2] = matrix.row_w;

   assign en = !s3_vld_ff || job_rdy;
   assign req_chan.ready = en;

   // sign and magnitude of the x and y dot products, visibility against w
   always_comb begin
      logic signed [DOT_W-1:0] ax;
      logic signed [DOT_W-1:0] ay;
      ax = (dot_ff[0] < 0) ? -dot_ff[0] : dot_ff[0];
      ay = (dot_ff[1] < 0) ? -dot_ff[1] : dot_ff[1];
      job_in.mag_x = ax[MAG_W-1:0];
      job_in.neg_x = dot_ff[0] < 0;
      job_in.mag_y = ay[MAG_W-1:0];
      job_in.neg_y = dot_ff[1] < 0;
      job_in.div   = dot_ff[2][MAG_W-1:0];
      job_in.vis   = dot_ff[2] >= WMIN_S;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_chan.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= MUL_W'($signed(rows[r][c])) * MUL_W'(pt[c]);
            end
            c3_ff[r]  <= $signed(rows[r][3]);
            dot_ff[r] <= DOT_W'(prod_ff[r][0] >>> FRAC_W) + DOT_W'(prod_ff[r][1] >>> FRAC_W)
                       + DOT_W'(prod_ff[r][2] >>> FRAC_W) + DOT_W'(c3_ff[r]);
         end
         job_ff <= job_in;
      end
   end

   assign job     = job_ff;
   assign job_vld = s3_vld_ff;

endmodule

// File: sv/wtsp_fifo.sv
module wtsp_fifo import wtsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type din,
   output logic    full,
   input  logic    pop,
   output job_type dout,
   output logic    empty
);

   job_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, rd_ff;
   logic [FIFO_AW:0]   cnt_ff, cnt_in;

   assign full  = cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH);
   assign empty = cnt_ff == '0;
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

// File: sv/wtsp_back.sv
module wtsp_back import wtsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  job_type      job,
   input  logic         job_vld,
   output logic         job_pop,
   input  viewport_type vp,
   wtsp_rsp_if.source   rsp_chan
);

   localparam logic [Q_W-1:0] RATIO_MAX = Q_W'(1) << (Q_W - 1);
   localparam logic signed [SUM_W-1:0] OFS_HALF = SUM_W'(32768);

   logic          en;
   div_stage_type st_ff [NSTEP+1];
   div_stage_type st_in [NSTEP+1];

   logic              m_vld_ff, m_vis_ff, m_neg_x_ff, m_neg_y_ff;
   logic [HALF_W-1:0] m_x_ff, m_y_ff;
   logic              out_vld_ff, out_vis_ff;
   coord_type         out_x_ff, out_y_ff;

   assign en      = !out_vld_ff || rsp_chan.ready;
   assign job_pop = en && job_vld;

   // long division, one quotient bit per stage, x and y share the divisor
   always_comb begin
      logic [MAG_W:0] tx, ty;
      logic           gx, gy;
      st_in[0].vld   = job_vld;
      st_in[0].vis   = job.vis;
      st_in[0].neg_x = job.neg_x;
      st_in[0].neg_y = job.neg_y;
      st_in[0].div   = job.div;
      st_in[0].ovf_x = (job.mag_x >> HI_SHIFT) >= job.div;
      st_in[0].ovf_y = (job.mag_y >> HI_SHIFT) >= job.div;
      st_in[0].rem_x = job.mag_x >> HI_SHIFT;
      st_in[0].rem_y = job.mag_y >> HI_SHIFT;
      st_in[0].num_x = {job.mag_x[HI_SHIFT-1:0], FRAC_W'(0)};
      st_in[0].num_y = {job.mag_y[HI_SHIFT-1:0], FRAC_W'(0)};
      st_in[0].quo_x = '0;
      st_in[0].quo_y = '0;
      for (int k = 0; k < NSTEP; k++) begin
         tx = {st_ff[k].rem_x, st_ff[k].num_x[Q_W-1]};
         ty = {st_ff[k].rem_y, st_ff[k].num_y[Q_W-1]};
         gx = tx >= {1'b0, st_ff[k].div};
         gy = ty >= {1'b0, st_ff[k].div};
         st_in[k+1]       = st_ff[k];
         st_in[k+1].rem_x = gx ? MAG_W'(tx - {1'b0, st_ff[k].div}) : tx[MAG_W-1:0];
         st_in[k+1].rem_y = gy ? MAG_W'(ty - {1'b0, st_ff[k].div}) : ty[MAG_W-1:0];
         st_in[k+1].num_x = st_ff[k].num_x << 1;
         st_in[k+1].num_y = st_ff[k].num_y << 1;
         st_in[k+1].quo_x = {st_ff[k].quo_x[Q_W-2:0], gx};
         st_in[k+1].quo_y = {st_ff[k].quo_y[Q_W-2:0], gy};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NSTEP; k++) begin
            st_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         st_ff <= st_in;
      end
   end

   // clamp the ratio and scale by the viewport size
   logic [Q_W-1:0]    qx, qy;
   logic [PROD_W-1:0] px, py;

   always_comb begin
      qx = (st_ff[NSTEP].ovf_x || st_ff[NSTEP].quo_x > RATIO_MAX) ? RATIO_MAX
                                                                  : st_ff[NSTEP].quo_x;
      qy = (st_ff[NSTEP].ovf_y || st_ff[NSTEP].quo_y > RATIO_MAX) ? RATIO_MAX
                                                                  : st_ff[NSTEP].quo_y;
      px = PROD_W'(qx) * PROD_W'(vp.width);
      py = PROD_W'(qy) * PROD_W'(vp.height);
   end

   // viewport mapping and saturation
   logic signed [SUM_W-1:0] hx, hy, sx, sy;

   always_comb begin
      hx = SUM_W'($signed({1'b0, m_x_ff}));
      hy = SUM_W'($signed({1'b0, m_y_ff}));
      if (m_neg_x_ff) begin
         hx = -hx;
      end
      if (m_neg_y_ff) begin
         hy = -hy;
      end
      sx = $signed(SUM_W'({vp.width[VP_W-1:1], FRAC_W'(0)})) + hx + OFS_HALF
         + SUM_W'($signed({vp.left, FRAC_W'(0)}));
      sy = $signed(SUM_W'({vp.height[VP_W-1:1], FRAC_W'(0)})) - (hy + OFS_HALF)
         + SUM_W'($signed({vp.top, FRAC_W'(0)}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff   <= st_ff[NSTEP].vld;
         out_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_vis_ff   <= st_ff[NSTEP].vis;
         m_neg_x_ff <= st_ff[NSTEP].neg_x;
         m_neg_y_ff <= st_ff[NSTEP].neg_y;
         m_x_ff     <= px[PROD_W-1:1];
         m_y_ff     <= py[PROD_W-1:1];
         out_vis_ff <= m_vis_ff;
         out_x_ff   <= m_vis_ff ? sat32(sx) : '0;
         out_y_ff   <= m_vis_ff ? sat32(sy) : '0;
      end
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.screen_x  = out_x_ff;
   assign rsp_chan.screen_y  = out_y_ff;
   assign rsp_chan.on_screen = out_vis_ff;

endmodule

// File: sv/world_to_screen_projection_unit.sv
// perspective projection of q16.16 world points to viewport coordinates. a point
// goes in on req_chan and one beat comes out on rsp_chan. the block takes one beat
// per cycle while rsp_chan is not stalled; a beat may wait in the 4-deep queue
// between the front (three rows of matrix products, sums and visibility test,
// 3 stages) and the back (35-stage long divider giving one quotient bit per stage,
// a scaling multiply and the output register).
// the matrix and viewport registers are to be written by the user through the
// csr_ port only while no point is in flight; the block does not enforce it.
module world_to_screen_projection_unit import wtsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wtsp_req_if.sink              req_chan,
   wtsp_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [CSR_DATA_W-1:0] row0_lo_ff, row0_hi_ff, row1_lo_ff, row1_hi_ff;
   logic [CSR_DATA_W-1:0] row3_lo_ff, row3_hi_ff;
   logic [31:0]           vp_org_ff, vp_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_lo_ff <= '0;
         row0_hi_ff <= '0;
         row1_lo_ff <= '0;
         row1_hi_ff <= '0;
         row3_lo_ff <= '0;
         row3_hi_ff <= '0;
         vp_org_ff  <= '0;
         vp_size_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROW0_LO: row0_lo_ff <= csr_wdata;
            CSR_ROW0_HI: row0_hi_ff <= csr_wdata;
            CSR_ROW1_LO: row1_lo_ff <= csr_wdata;
            CSR_ROW1_HI: row1_hi_ff <= csr_wdata;
            CSR_ROW3_LO: row3_lo_ff <= csr_wdata;
            CSR_ROW3_HI: row3_hi_ff <= csr_wdata;
            CSR_VP_ORG:  vp_org_ff  <= csr_wdata[31:0];
            CSR_VP_SIZE: vp_size_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // coefficient 0 sits in the low word, coefficient 3 in the top word
   matrix_type   matrix;
   viewport_type vp;

   assign matrix.row_x = {row0_hi_ff, row0_lo_ff};
   assign matrix.row_y = {row1_hi_ff, row1_lo_ff};
   assign matrix.row_w = {row3_hi_ff, row3_lo_ff};
   assign vp = {vp_org_ff, vp_size_ff};

   // front: dot products and classification
   job_type front_job;
   logic    front_vld;
   logic    q_full;

   wtsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .matrix   (matrix),
      .job      (front_job),
      .job_vld  (front_vld),
      .job_rdy  (!q_full)
   );

   // decoupling queue
   job_type q_job;
   logic    q_empty;
   logic    q_pop;

   wtsp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (front_vld && !q_full),
      .din   (front_job),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_job),
      .empty (q_empty)
   );

   // back: division, scaling, viewport mapping
   wtsp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job      (q_job),
      .job_vld  (!q_empty),
      .job_pop  (q_pop),
      .vp       (vp),
      .rsp_chan (rsp_chan)
   );

endmodule
